[rtl/core/cgbe_pkg.sv]
package cgbe_pkg;

   localparam int MAX_DEGREE = 3;
   localparam int COEF_BITS  = 16;

   localparam int LANE_W  = 16;
   localparam int N_LANES = 4;
   localparam int CSR_W   = LANE_W * N_LANES;
   localparam int IDX_W   = 3;
   localparam int DEG_W   = 2;
   localparam int VAL_W   = 16;
   localparam int DENS_W  = 16;

   localparam int FRAC_W = 16;
   localparam int P_W    = COEF_BITS + FRAC_W;
   localparam int T_W    = FRAC_W + 1;
   localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

   localparam int A_W     = 2 * FRAC_W + 1;
   localparam int B_W     = P_W;
   localparam int Z_LIMIT = 6;
   localparam int DIV_PRE = 3;
   localparam int DIV_STEPS     = FRAC_W + 1 + DIV_PRE;
   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
   localparam int R_W = DIV_STEPS - 1;

   localparam int Q_SHIFT      = FRAC_W + 1;
   localparam int N_W          = 5;
   localparam int EXP_MAX_N    = 17;
   localparam int TAYLOR_TERMS = 10;
   localparam int TK_W         = $clog2(TAYLOR_TERMS + 1);
   localparam int TERM_W       = 2 * FRAC_W;
   localparam int SUM_W        = TERM_W + 2;
   localparam int V_W          = TERM_W + 1;
   localparam logic [SUM_W-1:0] ONE_Q32 = SUM_W'(64'h1_0000_0000);
   localparam logic [30:0] EXP_M1 = 31'd1580030169;
   localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

   localparam logic [CSR_W-1:0] SIGMA_RESET = 64'h0100_0100_0100_0100;
   localparam logic [15:0] RECIP_RESET = 16'd256;

   typedef enum logic [IDX_W-1:0] {
      CSR_MEAN_COEFS   = 3'd0,
      CSR_SIGMA_COEFS  = 3'd1,
      CSR_MEAN_DEGREE  = 3'd2,
      CSR_SIGMA_DEGREE = 3'd3,
      CSR_Y_LOW        = 3'd4,
      CSR_Y_SPAN_RECIP = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [CSR_W-1:0]        mean_coefs;
      logic [CSR_W-1:0]        sigma_coefs;
      logic [DEG_W-1:0]        mean_degree;
      logic [DEG_W-1:0]        sigma_degree;
      logic signed [VAL_W-1:0] y_low;
      logic [15:0]             y_span_recip;
   } cfg_type;

   typedef struct packed {
      logic [DENS_W-1:0] density;
      logic              zero_width;
   } rsp_type;

   typedef struct packed {
      logic [FRAC_W-1:0] f;
      logic [N_W-1:0]    n;
      logic              zero;
      logic              far;
   } side_type;

   function automatic logic signed [P_W-1:0] lane_coef(input logic [CSR_W-1:0] r,
                                                       input int k);
      logic [COEF_BITS-1:0] c;
      c = r[LANE_W*k +: COEF_BITS];
      return $signed({c, {FRAC_W{1'b0}}});
   endfunction

   function automatic logic signed [P_W-1:0] lerp(input logic signed [P_W-1:0] p0,
                                                  input logic signed [P_W-1:0] p1,
                                                  input logic [T_W-1:0] t);
      logic signed [T_W:0]        ss;
      logic signed [T_W:0]        ts;
      logic signed [P_W+T_W+1:0]  acc;
      ss  = $signed({1'b0, T_ONE - t});
      ts  = $signed({1'b0, t});
      acc = p0 * ss + p1 * ts + $signed((P_W+T_W+2)'(1 << (FRAC_W - 1)));
      return P_W'(acc >>> FRAC_W);
   endfunction

endpackage

[rtl/core/cgbe_if.sv]
interface cgbe_req_if;
   import cgbe_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] x_value;
   logic signed [VAL_W-1:0] y_value;
   modport source (output valid, x_value, y_value, input ready);
   modport sink (input valid, x_value, y_value, output ready);
endinterface

interface cgbe_rsp_if;
   import cgbe_pkg::*;
   logic              valid;
   logic              ready;
   logic [DENS_W-1:0] density;
   logic              zero_width;
   modport source (output valid, density, zero_width, input ready);
   modport sink (input valid, density, zero_width, output ready);
endinterface

interface cgbe_csr_if;
   import cgbe_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CSR_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

[rtl/core/conditional_gauss_bernstein_eval_top.sv]
// Throughput: one item per cycle while the pipeline is not stalled; the
// 62-register pipeline advances in lockstep.
// A two-entry output stage holds a finished result while the pipeline keeps taking
// items; the pipeline stalls only when both entries are full.
// Reset (synchronous): clears all valid bits and loads the register defaults.
module conditional_gauss_bernstein_eval_top (
   input  logic        clock,
   input  logic        reset,
   cgbe_req_if.sink    req_if,
   cgbe_rsp_if.source  rsp_if,
   cgbe_csr_if.sink    csr_if
);
   import cgbe_pkg::*;

   cfg_type        cfg;
   logic           en;
   logic           bv;
   logic [A_W-1:0] ba;
   logic [B_W-1:0] bb;
   logic           bz;
   logic           bf;
   logic           dv;
   logic [R_W-1:0] dr;
   logic           dz;
   logic           df;
   logic           pipe_v;
   rsp_type        pipe_item;

   logic           out_v_ff;
   logic           skid_v_ff;
   rsp_type        out_ff;
   rsp_type        skid_ff;
   logic           take;

   cgbe_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   cgbe_bern u_bern (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .in_x      (req_if.x_value),
      .in_y      (req_if.y_value),
      .cfg       (cfg),
      .out_valid (bv),
      .out_a     (ba),
      .out_b     (bb),
      .out_zero  (bz),
      .out_far   (bf)
   );

   cgbe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (bv),
      .in_a      (ba),
      .in_b      (bb),
      .in_zero   (bz),
      .in_far    (bf),
      .out_valid (dv),
      .out_r     (dr),
      .out_zero  (dz),
      .out_far   (df)
   );

   cgbe_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv),
      .in_r      (dr),
      .in_zero   (dz),
      .in_far    (df),
      .out_valid (pipe_v),
      .out_item  (pipe_item)
   );

   assign en                = !skid_v_ff;
   assign req_if.ready      = en;
   assign take              = out_v_ff && rsp_if.ready;
   assign rsp_if.valid      = out_v_ff;
   assign rsp_if.density    = out_ff.density;
   assign rsp_if.zero_width = out_ff.zero_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         priority if (skid_v_ff) begin
            if (take) begin
               skid_v_ff <= 1'b0;
            end
         end else if (pipe_v) begin
            if (out_v_ff && !take) begin
               skid_v_ff <= 1'b1;
            end else begin
               out_v_ff <= 1'b1;
            end
         end else if (take) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (pipe_v) begin
         if (out_v_ff && !take) begin
            skid_ff <= pipe_item;
         end else begin
            out_ff <= pipe_item;
         end
      end else begin
         out_ff <= out_ff;
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid while output entry empty");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (!skid_v_ff && pipe_v && out_v_ff && !rsp_if.ready) |=> skid_v_ff)
      else $error("pipeline item dropped on output stall");

   a_zero_density: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.zero_width) |-> (rsp_if.density == '0))
      else $error("nonzero density with zero width");

endmodule

[rtl/core/cgbe_csr.sv]
module cgbe_csr (
   input  logic              clock,
   input  logic              reset,
   cgbe_csr_if.sink          csr_if,
   output cgbe_pkg::cfg_type cfg
);
   import cgbe_pkg::*;

   cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_coefs   <= '0;
         cfg_ff.sigma_coefs  <= SIGMA_RESET;
         cfg_ff.mean_degree  <= '0;
         cfg_ff.sigma_degree <= '0;
         cfg_ff.y_low        <= '0;
         cfg_ff.y_span_recip <= RECIP_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.index))
            CSR_MEAN_COEFS:   cfg_ff.mean_coefs   <= csr_if.wdata;
            CSR_SIGMA_COEFS:  cfg_ff.sigma_coefs  <= csr_if.wdata;
            CSR_MEAN_DEGREE:  cfg_ff.mean_degree  <= csr_if.wdata[DEG_W-1:0];
            CSR_SIGMA_DEGREE: cfg_ff.sigma_degree <= csr_if.wdata[DEG_W-1:0];
            CSR_Y_LOW:        cfg_ff.y_low        <= $signed(csr_if.wdata[VAL_W-1:0]);
            CSR_Y_SPAN_RECIP: cfg_ff.y_span_recip <= csr_if.wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule

[rtl/core/cgbe_bern.sv]
module cgbe_bern (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [cgbe_pkg::VAL_W-1:0] in_x,
   input  logic signed [cgbe_pkg::VAL_W-1:0] in_y,
   input  cgbe_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output logic [cgbe_pkg::A_W-1:0]       out_a,
   output logic [cgbe_pkg::B_W-1:0]       out_b,
   output logic                           out_zero,
   output logic                           out_far
);
   import cgbe_pkg::*;

   localparam int TY_W = 2 * (VAL_W + 1);
   localparam int FW   = A_W + 3;

   logic                    v_ff [0:MAX_DEGREE];
   logic signed [VAL_W-1:0] x_ff [0:MAX_DEGREE];
   logic [T_W-1:0]          t_ff [0:MAX_DEGREE];
   logic signed [P_W-1:0]   mp_ff [0:MAX_DEGREE][0:MAX_DEGREE];
   logic signed [P_W-1:0]   sp_ff [0:MAX_DEGREE][0:MAX_DEGREE];

   logic signed [VAL_W:0]   dy;
   logic signed [TY_W-1:0]  ty;
   logic [T_W-1:0]          t_in;
   logic [DEG_W-1:0]        mdeg;
   logic [DEG_W-1:0]        sdeg;

   assign mdeg = (int'(cfg.mean_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg.mean_degree;
   assign sdeg = (int'(cfg.sigma_degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg.sigma_degree;

   always_comb begin
      dy = (VAL_W+1)'(in_y) - (VAL_W+1)'(cfg.y_low);
      ty = dy * $signed({1'b0, cfg.y_span_recip});
      priority if (ty < 0) begin
         t_in = '0;
      end else if (ty > TY_W'(T_ONE)) begin
         t_in = T_ONE;
      end else begin
         t_in = T_W'(ty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= in_x;
         t_ff[0] <= t_in;
         for (int i = 0; i <= MAX_DEGREE; i++) begin
            mp_ff[0][i] <= lane_coef(cfg.mean_coefs, i);
            sp_ff[0][i] <= lane_coef(cfg.sigma_coefs, i);
         end
      end
   end

   for (genvar lvl = 1; lvl <= MAX_DEGREE; lvl++) begin : g_lvl
      logic signed [P_W-1:0] mnext [0:MAX_DEGREE];
      logic signed [P_W-1:0] snext [0:MAX_DEGREE];

      always_comb begin
         for (int i = 0; i <= MAX_DEGREE; i++) begin
            mnext[i] = mp_ff[lvl-1][i];
            snext[i] = sp_ff[lvl-1][i];
         end
         for (int i = 0; i <= MAX_DEGREE - lvl; i++) begin
            if (int'(mdeg) >= lvl) begin
               mnext[i] = lerp(mp_ff[lvl-1][i], mp_ff[lvl-1][i+1], t_ff[lvl-1]);
            end
            if (int'(sdeg) >= lvl) begin
               snext[i] = lerp(sp_ff[lvl-1][i], sp_ff[lvl-1][i+1], t_ff[lvl-1]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[lvl] <= 1'b0;
         end else if (en) begin
            v_ff[lvl] <= v_ff[lvl-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[lvl] <= x_ff[lvl-1];
            t_ff[lvl] <= t_ff[lvl-1];
            for (int i = 0; i <= MAX_DEGREE; i++) begin
               mp_ff[lvl][i] <= mnext[i];
               sp_ff[lvl][i] <= snext[i];
            end
         end
      end
   end

   logic signed [A_W-1:0] xs;
   logic signed [A_W-1:0] arg;
   logic signed [P_W-1:0] sg;
   logic [A_W-1:0]        a_in;
   logic [B_W-1:0]        b_in;
   logic [FW-1:0]         b6;

   logic                  vo_ff;
   logic [A_W-1:0]        a_ff;
   logic [B_W-1:0]        b_ff;
   logic                  zero_ff;
   logic                  far_ff;

   always_comb begin
      xs   = A_W'($signed({x_ff[MAX_DEGREE], {FRAC_W{1'b0}}}));
      arg  = xs - A_W'(mp_ff[MAX_DEGREE][0]);
      sg   = sp_ff[MAX_DEGREE][0];
      a_in = arg[A_W-1] ? A_W'(-arg) : A_W'(arg);
      b_in = sg[P_W-1] ? B_W'(-sg) : B_W'(sg);
      b6   = FW'(b_in) * FW'(Z_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[MAX_DEGREE];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         zero_ff <= (sg == '0);
         far_ff  <= (FW'(a_in) >= b6);
      end
   end

   assign out_valid = vo_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_zero  = zero_ff;
   assign out_far   = far_ff;

endmodule

[rtl/core/cgbe_div.sv]
module cgbe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [cgbe_pkg::A_W-1:0]   in_a,
   input  logic [cgbe_pkg::B_W-1:0]   in_b,
   input  logic                       in_zero,
   input  logic                       in_far,
   output logic                       out_valid,
   output logic [cgbe_pkg::R_W-1:0]   out_r,
   output logic                       out_zero,
   output logic                       out_far
);
   import cgbe_pkg::*;

   logic                 v_ff    [0:DIV_STAGES-1];
   logic [B_W-1:0]       rem_ff  [0:DIV_STAGES-1];
   logic [B_W-1:0]       b_ff    [0:DIV_STAGES-1];
   logic [DIV_STEPS-1:0] bits_ff [0:DIV_STAGES-1];
   logic [DIV_STEPS-1:0] quo_ff  [0:DIV_STAGES-1];
   logic                 zero_ff [0:DIV_STAGES-1];
   logic                 far_ff  [0:DIV_STAGES-1];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
      logic                 vi;
      logic [B_W-1:0]       rem_i;
      logic [B_W-1:0]       b_i;
      logic [DIV_STEPS-1:0] bits_i;
      logic [DIV_STEPS-1:0] quo_i;
      logic                 zero_i;
      logic                 far_i;
      logic [B_W-1:0]       rem_o;
      logic [DIV_STEPS-1:0] bits_o;
      logic [DIV_STEPS-1:0] quo_o;
      logic [B_W:0]         r2;

      if (s == 0) begin : g_first
         assign vi     = in_valid;
         assign rem_i  = B_W'(in_a >> DIV_PRE);
         assign b_i    = in_b;
         assign bits_i = {in_a[DIV_PRE-1:0], {(DIV_STEPS-DIV_PRE){1'b0}}};
         assign quo_i  = '0;
         assign zero_i = in_zero;
         assign far_i  = in_far;
      end else begin : g_next
         assign vi     = v_ff[s-1];
         assign rem_i  = rem_ff[s-1];
         assign b_i    = b_ff[s-1];
         assign bits_i = bits_ff[s-1];
         assign quo_i  = quo_ff[s-1];
         assign zero_i = zero_ff[s-1];
         assign far_i  = far_ff[s-1];
      end

      always_comb begin
         rem_o  = rem_i;
         bits_o = bits_i;
         quo_o  = quo_i;
         r2     = '0;
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            r2     = {rem_o, bits_o[DIV_STEPS-1]};
            bits_o = bits_o << 1;
            if (r2 >= {1'b0, b_i}) begin
               rem_o = B_W'(r2 - {1'b0, b_i});
               quo_o = {quo_o[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_o = B_W'(r2);
               quo_o = {quo_o[DIV_STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_o;
            b_ff[s]    <= b_i;
            bits_ff[s] <= bits_o;
            quo_ff[s]  <= quo_o;
            zero_ff[s] <= zero_i;
            far_ff[s]  <= far_i;
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_r     = quo_ff[DIV_STAGES-1][DIV_STEPS-1:1];
   assign out_zero  = zero_ff[DIV_STAGES-1];
   assign out_far   = far_ff[DIV_STAGES-1];

endmodule

[rtl/core/cgbe_exp.sv]
module cgbe_exp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [cgbe_pkg::R_W-1:0] in_r,
   input  logic                     in_zero,
   input  logic                     in_far,
   output logic                     out_valid,
   output cgbe_pkg::rsp_type        out_item
);
   import cgbe_pkg::*;

   logic [2*R_W-1:0] rr;
   assign rr = in_r * in_r;

   logic                    tv_ff   [1:TAYLOR_TERMS];
   logic [TERM_W-1:0]       term_ff [1:TAYLOR_TERMS];
   logic signed [SUM_W-1:0] sum_ff  [1:TAYLOR_TERMS];
   side_type                side_ff [1:TAYLOR_TERMS];

   logic [TERM_W-1:0] term1;
   side_type          side_in;

   always_comb begin
      side_in.f    = rr[Q_SHIFT +: FRAC_W];
      side_in.n    = rr[Q_SHIFT+FRAC_W +: N_W];
      side_in.zero = in_zero;
      side_in.far  = in_far;
      term1        = {side_in.f, {FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff[1] <= 1'b0;
      end else if (en) begin
         tv_ff[1] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff[1] <= term1;
         sum_ff[1]  <= $signed(ONE_Q32 - SUM_W'(term1));
         side_ff[1] <= side_in;
      end
   end

   for (genvar k = 2; k <= TAYLOR_TERMS; k++) begin : g_term
      localparam logic [TERM_W-1:0] RM = TERM_W'((64'd1 << TERM_W) / k);
      localparam logic [TK_W-1:0]   KC = TK_W'(k);

      logic                    va_ff;
      logic                    vb_ff;
      side_type                sa_ff;
      side_type                sb_ff;
      logic signed [SUM_W-1:0] suma_ff;
      logic signed [SUM_W-1:0] sumb_ff;
      logic [TERM_W+FRAC_W-1:0] pa_ff;
      logic [TERM_W-1:0]       xb_ff;
      logic [2*TERM_W-1:0]     mb_ff;
      logic [TERM_W-1:0]       xa;
      logic [TERM_W-1:0]       qe;
      logic [TERM_W-1:0]       qc;
      logic [TERM_W+TK_W-1:0]  qk;
      logic [TERM_W+TK_W-1:0]  rem;
      logic signed [SUM_W-1:0] sum_next;

      always_comb begin
         xa  = TERM_W'(pa_ff >> FRAC_W);
         qe  = TERM_W'(mb_ff >> TERM_W);
         qk  = qe * KC;
         rem = (TERM_W+TK_W)'(xb_ff) - qk;
         qc  = (rem >= (TERM_W+TK_W)'(KC)) ? qe + 1'b1 : qe;
         if (k % 2 == 1) begin
            sum_next = sumb_ff - $signed(SUM_W'(qc));
         end else begin
            sum_next = sumb_ff + $signed(SUM_W'(qc));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff    <= 1'b0;
            vb_ff    <= 1'b0;
            tv_ff[k] <= 1'b0;
         end else if (en) begin
            va_ff    <= tv_ff[k-1];
            vb_ff    <= va_ff;
            tv_ff[k] <= vb_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff      <= term_ff[k-1] * side_ff[k-1].f;
            suma_ff    <= sum_ff[k-1];
            sa_ff      <= side_ff[k-1];
            xb_ff      <= xa;
            mb_ff      <= xa * RM;
            sumb_ff    <= suma_ff;
            sb_ff      <= sa_ff;
            term_ff[k] <= qc;
            sum_ff[k]  <= sum_next;
            side_ff[k] <= sb_ff;
         end
      end
   end

   logic                    ev_ff [0:EXP_MAX_N];
   logic [V_W-1:0]          vv_ff [0:EXP_MAX_N];
   side_type                es_ff [0:EXP_MAX_N];
   logic signed [SUM_W-1:0] st;
   logic [V_W-1:0]          vclamp;

   always_comb begin
      st = sum_ff[TAYLOR_TERMS];
      priority if (st < 0) begin
         vclamp = '0;
      end else if (st > $signed(ONE_Q32)) begin
         vclamp = V_W'(ONE_Q32);
      end else begin
         vclamp = V_W'(st);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff[0] <= 1'b0;
      end else if (en) begin
         ev_ff[0] <= tv_ff[TAYLOR_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vv_ff[0] <= vclamp;
         es_ff[0] <= side_ff[TAYLOR_TERMS];
      end
   end

   for (genvar j = 0; j < EXP_MAX_N; j++) begin : g_em1
      logic [V_W+30:0] pm;
      logic [V_W-1:0]  vnext;

      always_comb begin
         pm    = vv_ff[j] * EXP_M1 + (V_W+31)'(HALF_Q32);
         vnext = (N_W'(j) < es_ff[j].n) ? V_W'(pm >> 32) : vv_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ev_ff[j+1] <= 1'b0;
         end else if (en) begin
            ev_ff[j+1] <= ev_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vv_ff[j+1] <= vnext;
            es_ff[j+1] <= es_ff[j];
         end
      end
   end

   logic [V_W+FRAC_W-1:0]   dw;
   logic [V_W+FRAC_W-33:0]  dhi;
   rsp_type                 res;
   logic                    ov_ff;
   rsp_type                 item_ff;

   always_comb begin
      dw  = {vv_ff[EXP_MAX_N], {FRAC_W{1'b0}}} - (V_W+FRAC_W)'(vv_ff[EXP_MAX_N])
            + (V_W+FRAC_W)'(HALF_Q32);
      dhi = dw[V_W+FRAC_W-1:32];
      res.zero_width = es_ff[EXP_MAX_N].zero;
      if (es_ff[EXP_MAX_N].zero || es_ff[EXP_MAX_N].far) begin
         res.density = '0;
      end else if (dhi > (V_W+FRAC_W-32)'({DENS_W{1'b1}})) begin
         res.density = {DENS_W{1'b1}};
      end else begin
         res.density = DENS_W'(dhi);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= ev_ff[EXP_MAX_N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= res;
      end
   end

   assign out_valid = ov_ff;
   assign out_item  = item_ff;

endmodule
